[src/dsd_pkg.sv]
// Package for the disk signed-distance pipeline: payload types, register
// indexes and the fixed-point widths shared by the datapath and root unit.
// No dependencies.
`default_nettype none

package dsd_pkg;

    // Normal vector fraction bits (Q1.14)
    localparam int NORMAL_FRAC_BITS = 14;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int COORD_W = 32;
    localparam int NORM_W  = 16;
    localparam int RAD_CFG_W = 31;
    localparam int D_W     = COORD_W + 1;              // center - point
    localparam int DN_W    = D_W + NORM_W;             // d * n
    localparam int RS_W    = DN_W + 3;                 // dot product plus rounding
    localparam int H_W     = RS_W - NORMAL_FRAC_BITS;  // height along normal
    localparam int HN_W    = H_W + NORM_W;             // h * n
    localparam int RHN_W   = HN_W + 1 - NORMAL_FRAC_BITS;
    localparam int U_W     = RHN_W + 1;                // in-plane offset
    localparam int SQ_W    = 64;
    localparam int SUM_W   = SQ_W + 2;

    // Square-root unit widths
    localparam int ROOT_W  = 32;
    localparam int SRAD_W  = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] signed_distance;
    } dist_t;

endpackage

`default_nettype wire

[src/dsd_stream_if.sv]
// Valid/ready stream channel carrying one payload of type T.
// Used with dsd_pkg::point_t and dsd_pkg::dist_t.
`default_nettype none

interface dsd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/dsd_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband vector alongside. Depends on dsd_pkg.
`default_nettype none

module dsd_sqrt_pipe #(
    parameter int SIDE_W = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        ce,
    input  wire logic                        in_valid,
    input  wire logic [dsd_pkg::SRAD_W-1:0]  in_radicand,
    input  wire logic [SIDE_W-1:0]           in_side,
    output logic                             out_valid,
    output logic [dsd_pkg::ROOT_W-1:0]       out_root,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int N  = dsd_pkg::ROOT_W;
    localparam int RW = dsd_pkg::REM_W;
    localparam int XW = dsd_pkg::SRAD_W;

    logic [N-1:0]  valid_reg;
    logic [RW-1:0] rem_reg  [N];
    logic [N-1:0]  root_reg [N];
    logic [XW-1:0] x_reg    [N];
    logic [SIDE_W-1:0] side_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            logic          cur_valid;
            logic [RW-1:0] cur_rem;
            logic [N-1:0]  cur_root;
            logic [XW-1:0] cur_x;
            logic [SIDE_W-1:0] cur_side;
            logic [RW+1:0] trial;
            logic [RW+1:0] test;
            logic          ge;
            logic [RW-1:0] rem_next;
            logic [N-1:0]  root_next;

            if (k == 0) begin : g_first
                assign cur_valid = in_valid;
                assign cur_rem   = '0;
                assign cur_root  = '0;
                assign cur_x     = in_radicand;
                assign cur_side  = in_side;
            end else begin : g_rest
                assign cur_valid = valid_reg[k-1];
                assign cur_rem   = rem_reg[k-1];
                assign cur_root  = root_reg[k-1];
                assign cur_x     = x_reg[k-1];
                assign cur_side  = side_reg[k-1];
            end

            // Bring down the next two radicand bits and try root bit 1
            assign trial     = {cur_rem, cur_x[XW-1-2*k -: 2]};
            assign test      = (RW+2)'({cur_root, 2'b01});
            assign ge        = (trial >= test);
            assign rem_next  = ge ? RW'(trial - test) : RW'(trial);
            assign root_next = {cur_root[N-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ce)
                begin
                    valid_reg[k] <= cur_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    x_reg[k]    <= cur_x;
                    side_reg[k] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

[src/disk_signed_distance.sv]
// Signed distance from a stream of 3D points to a configured flat disk.
// Depends on dsd_pkg, dsd_stream_if and dsd_sqrt_pipe.
//
// Usage:
//   point  : sink channel, one Q16.16 point (x, y, z) per transfer.
//   result : source channel, one Q16.16 signed distance per point, in order,
//            negative inside the rim, saturated to 32 bits.
//   cfg_*  : register writes (center, normal, radius); write only while no
//            point is in flight.
// Throughput: one point per cycle while the skid register is empty.
// Pipeline: 76 register stages from a point transfer to its result,
//   the first loaded at the transfer edge:
//   eight arithmetic stages, a 32-stage square root of |u|^2, three stages
//   for the rim distance and its squares, a second 32-stage square root,
//   and the output register.
// Stalls: the whole pipeline moves on one shared enable. A two-entry output
//   buffer (output register plus skid register) absorbs the result that
//   arrives while the receiver holds ready low; the pipeline freezes only
//   once the skid register is full, and nothing is dropped or repeated.
// Reset: clears all valid bits and the output buffer; the disk resets to
//   center 0, normal +z, radius 1.0.
`default_nettype none

module disk_signed_distance (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [dsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    dsd_stream_if.sink                            point,
    dsd_stream_if.source                          result
);

    localparam int D_W   = dsd_pkg::D_W;
    localparam int DN_W  = dsd_pkg::DN_W;
    localparam int RS_W  = dsd_pkg::RS_W;
    localparam int H_W   = dsd_pkg::H_W;
    localparam int HN_W  = dsd_pkg::HN_W;
    localparam int RHN_W = dsd_pkg::RHN_W;
    localparam int U_W   = dsd_pkg::U_W;
    localparam int NFB   = dsd_pkg::NORMAL_FRAC_BITS;
    localparam int SUM_W = dsd_pkg::SUM_W;
    localparam int SQ_W  = dsd_pkg::SQ_W;
    localparam int RT_W  = dsd_pkg::ROOT_W;
    localparam int CW    = dsd_pkg::COORD_W;
    localparam int NW    = dsd_pkg::NORM_W;
    localparam logic signed [RS_W-1:0]    RS_HALF  = RS_W'(1) <<< (NFB - 1);
    localparam logic signed [RHN_W+NFB-1:0] RHN_HALF = (RHN_W+NFB)'(1) <<< (NFB - 1);

    // ---------------- configuration registers ----------------
    logic signed [CW-1:0] center_reg [3];
    logic signed [NW-1:0] normal_reg [3];
    logic [dsd_pkg::RAD_CFG_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= 16'sd16384;
            radius_reg    <= 31'd65536;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dsd_pkg::REG_CENTER_X: center_reg[0] <= cfg_wdata;
                dsd_pkg::REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                dsd_pkg::REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                dsd_pkg::REG_NORMAL_X: normal_reg[0] <= cfg_wdata[NW-1:0];
                dsd_pkg::REG_NORMAL_Y: normal_reg[1] <= cfg_wdata[NW-1:0];
                dsd_pkg::REG_NORMAL_Z: normal_reg[2] <= cfg_wdata[NW-1:0];
                dsd_pkg::REG_RADIUS:   radius_reg <= cfg_wdata[dsd_pkg::RAD_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline enable and output buffer ----------------
    logic ce;
    logic out_valid_reg, skid_valid_reg;
    dsd_pkg::dist_t out_data_reg, skid_data_reg;
    logic last_valid;
    dsd_pkg::dist_t last_data;
    logic take, incoming;

    assign ce          = !skid_valid_reg;
    assign point.ready = ce;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
    assign take     = out_valid_reg && result.ready;
    assign incoming = ce && last_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= last_data;
            end
            else
            begin
                out_data_reg <= last_data;
            end
        end
    end

    // ---------------- front stages: height and in-plane offset ----------------
    logic [7:0] v_reg;   // valid bits of stages 1..8

    logic signed [D_W-1:0]   s1_d_reg  [3];
    logic signed [D_W-1:0]   s2_d_reg  [3];
    logic signed [DN_W-1:0]  s2_dn_reg [3];
    logic signed [D_W-1:0]   s3_d_reg  [3];
    logic signed [H_W-1:0]   s3_h_reg;
    logic signed [D_W-1:0]   s4_d_reg  [3];
    logic signed [HN_W-1:0]  s4_hn_reg [3];
    logic signed [H_W-1:0]   s4_h_reg;
    logic signed [U_W-1:0]   s5_u_reg  [3];
    logic signed [H_W-1:0]   s5_h_reg;
    logic [RT_W-1:0]         s6_m_reg  [3];
    logic                    s6_big_reg;
    logic signed [H_W-1:0]   s6_h_reg;
    logic [SQ_W-1:0]         s7_sq_reg [3];
    logic                    s7_big_reg;
    logic signed [H_W-1:0]   s7_h_reg;
    logic [SQ_W-1:0]         s8_sum_reg;
    logic                    s8_sat_reg;
    logic signed [H_W-1:0]   s8_h_reg;

    logic signed [CW-1:0] pt [3];
    logic signed [RS_W-1:0] dot_next;
    logic signed [RHN_W+NFB-1:0] rhn_full [3];
    logic [U_W-1:0] u_abs [3];
    logic [SUM_W-1:0] sum_next;

    assign pt[0] = point.data.point_x;
    assign pt[1] = point.data.point_y;
    assign pt[2] = point.data.point_z;

    assign dot_next = RS_W'(s2_dn_reg[0]) + RS_W'(s2_dn_reg[1]) + RS_W'(s2_dn_reg[2])
                      + RS_HALF;
    assign sum_next = SUM_W'(s7_sq_reg[0]) + SUM_W'(s7_sq_reg[1]) + SUM_W'(s7_sq_reg[2]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rhn_full[i] = (RHN_W+NFB)'(s4_hn_reg[i]) + RHN_HALF;
            u_abs[i]    = s5_u_reg[i][U_W-1] ? U_W'(-s5_u_reg[i]) : U_W'(s5_u_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[6:0], point.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // stage 1: offset to center
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i] <= D_W'(center_reg[i]) - D_W'(pt[i]);
            end
            // stage 2: products with the normal
            for (int i = 0; i < 3; i++)
            begin
                s2_d_reg[i]  <= s1_d_reg[i];
                s2_dn_reg[i] <= DN_W'(s1_d_reg[i]) * DN_W'(normal_reg[i]);
            end
            // stage 3: dot product, rounded to coordinate scale
            s3_d_reg <= s2_d_reg;
            s3_h_reg <= H_W'(dot_next >>> NFB);
            // stage 4: height times normal
            for (int i = 0; i < 3; i++)
            begin
                s4_d_reg[i]  <= s3_d_reg[i];
                s4_hn_reg[i] <= HN_W'(s3_h_reg) * HN_W'(normal_reg[i]);
            end
            s4_h_reg <= s3_h_reg;
            // stage 5: in-plane offset
            for (int i = 0; i < 3; i++)
            begin
                s5_u_reg[i] <= U_W'(s4_d_reg[i]) - U_W'(RHN_W'(rhn_full[i] >>> NFB));
            end
            s5_h_reg <= s4_h_reg;
            // stage 6: magnitudes, flag any component at or above 2^32
            for (int i = 0; i < 3; i++)
            begin
                s6_m_reg[i] <= u_abs[i][RT_W-1:0];
            end
            s6_big_reg <= (|u_abs[0][U_W-1:RT_W]) || (|u_abs[1][U_W-1:RT_W])
                          || (|u_abs[2][U_W-1:RT_W]);
            s6_h_reg <= s5_h_reg;
            // stage 7: squares
            for (int i = 0; i < 3; i++)
            begin
                s7_sq_reg[i] <= SQ_W'(s6_m_reg[i]) * SQ_W'(s6_m_reg[i]);
            end
            s7_big_reg <= s6_big_reg;
            s7_h_reg   <= s6_h_reg;
            // stage 8: squared length, flag overflow of 64 bits
            s8_sum_reg <= sum_next[SQ_W-1:0];
            s8_sat_reg <= s7_big_reg || (|sum_next[SUM_W-1:SQ_W]);
            s8_h_reg   <= s7_h_reg;
        end
    end

    // ---------------- first root: length of the in-plane offset ----------------
    localparam int SIDE1_W = H_W + 1;
    logic              r1_valid;
    logic [RT_W-1:0]   r1_root;
    logic [SIDE1_W-1:0] r1_side;

    dsd_sqrt_pipe #(.SIDE_W(SIDE1_W)) u_sqrt_len (
        .clk        (clk),
        .rst_n      (rst_n),
        .ce         (ce),
        .in_valid   (v_reg[7]),
        .in_radicand(s8_sum_reg),
        .in_side    ({s8_sat_reg, s8_h_reg}),
        .out_valid  (r1_valid),
        .out_root   (r1_root),
        .out_side   (r1_side)
    );

    // ---------------- rim distance and squares ----------------
    localparam int A_W  = RT_W + 3;
    localparam int AB_W = CW - 1;
    localparam int PP_W = 2 * AB_W;

    logic signed [A_W-1:0] a_val;
    logic signed [H_W-1:0] h_val;
    logic [H_W-1:0]        h_abs;
    logic [A_W-1:0]        a_abs;
    logic                  a_neg, a_big, h_big;

    assign h_val = r1_side[H_W-1:0];
    assign a_val = A_W'(r1_root) - A_W'(radius_reg);
    assign a_neg = a_val[A_W-1];
    assign a_abs = a_neg ? A_W'(-a_val) : A_W'(a_val);
    assign h_abs = h_val[H_W-1] ? H_W'(-h_val) : H_W'(h_val);
    assign a_big = !a_neg && (|a_val[A_W-2:AB_W]);
    assign h_big = |h_abs[H_W-1:AB_W];

    logic [2:0]       t_v_reg;
    logic [AB_W-1:0]  t1_a_reg, t1_h_reg;
    logic [2:0]       t1_fl_reg, t2_fl_reg, t3_fl_reg;  // {force, force_neg, neg}
    logic [PP_W-1:0]  t2_aa_reg, t2_hh_reg;
    logic [PP_W:0]    t3_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= '0;
        end
        else if (ce)
        begin
            t_v_reg <= {t_v_reg[1:0], r1_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // saturation decisions come first, in priority order
            t1_a_reg  <= a_abs[AB_W-1:0];
            t1_h_reg  <= h_abs[AB_W-1:0];
            t1_fl_reg <= {r1_side[H_W] || a_big || h_big,
                          !(r1_side[H_W] || a_big) && a_neg, a_neg};
            t2_aa_reg <= PP_W'(t1_a_reg) * PP_W'(t1_a_reg);
            t2_hh_reg <= PP_W'(t1_h_reg) * PP_W'(t1_h_reg);
            t2_fl_reg <= t1_fl_reg;
            t3_sq_reg <= (PP_W+1)'(t2_aa_reg) + (PP_W+1)'(t2_hh_reg);
            t3_fl_reg <= t2_fl_reg;
        end
    end

    // ---------------- second root: distance to the rim circle ----------------
    logic            r2_valid;
    logic [RT_W-1:0] r2_root;
    logic [2:0]      r2_fl;

    dsd_sqrt_pipe #(.SIDE_W(3)) u_sqrt_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ce         (ce),
        .in_valid   (t_v_reg[2]),
        .in_radicand(SQ_W'(t3_sq_reg)),
        .in_side    (t3_fl_reg),
        .out_valid  (r2_valid),
        .out_root   (r2_root),
        .out_side   (r2_fl)
    );

    // ---------------- sign and clamp into the output buffer ----------------
    always_comb
    begin
        last_valid = r2_valid;
        priority if (r2_fl[2])
        begin
            last_data.signed_distance = r2_fl[1] ? dsd_pkg::SAT_MIN : dsd_pkg::SAT_MAX;
        end
        else if (r2_fl[0])
        begin
            last_data.signed_distance = r2_root[RT_W-1] ? dsd_pkg::SAT_MIN
                                                        : CW'(-r2_root);
        end
        else
        begin
            last_data.signed_distance = r2_root[RT_W-1] ? dsd_pkg::SAT_MAX
                                                        : CW'(r2_root);
        end
    end

endmodule

`default_nettype wire
